### rtl/iol_pkg.sv
// Shared types and codes for the indexed ordered list.
package iol_pkg;

   localparam int VALUE_W  = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HEAD   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TAIL   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_AT     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   localparam logic signed [VALUE_W-1:0] READ_MISS = -32'sd1;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [STATUS_W-1:0]       status;
   } res_type;

endpackage

### rtl/iol_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iol_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/iol_seq.sv
// Request sequencer: decodes a request and moves elements one at a time through the RAM.
module iol_seq import iol_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [MODE_W-1:0]                 req_mode,
   input  logic [$clog2(CAPACITY+1)-1:0]     req_position,
   input  logic signed [VALUE_W-1:0]         req_value,
   input  logic                              out_free,
   output logic                              ready,
   output logic                              done,
   output res_type                           res,
   output logic [$clog2(CAPACITY+1)-1:0]     length,
   output logic                              wr_en,
   output logic [$clog2(CAPACITY)-1:0]       wr_addr,
   output logic [VALUE_W-1:0]                wr_data,
   output logic                              rd_en,
   output logic [$clog2(CAPACITY)-1:0]       rd_addr,
   input  logic [VALUE_W-1:0]                rd_data
);

   localparam int CntW  = $clog2(CAPACITY + 1);
   localparam int AddrW = $clog2(CAPACITY);
   localparam logic [CntW-1:0] CapCount = CntW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RD_WAIT,
      S_UP,
      S_UP_WR,
      S_DOWN,
      S_DN_WR,
      S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic [CntW-1:0]           pos_ff, pos_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [CntW-1:0]           idx_ff, idx_in;
   logic [CntW-1:0]           tgt_ff, tgt_in;
   logic [CntW-1:0]           count_ff, count_in;
   res_type                   res_ff, res_in;
   logic [CntW-1:0]           idx_p1;
   logic [CntW-1:0]           idx_m1;
   logic [CntW-1:0]           tgt;

   assign idx_p1 = idx_ff + CntW'(1);
   assign idx_m1 = idx_ff - CntW'(1);

   always_comb begin
      case (mode_ff)
         MODE_HEAD: tgt = '0;
         MODE_TAIL: tgt = count_ff;
         default:   tgt = pos_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      idx_in   = idx_ff;
      tgt_in   = tgt_ff;
      count_in = count_ff;
      res_in   = res_ff;
      done     = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AddrW-1:0];
      wr_data  = val_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_ff[AddrW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               pos_in   = req_position;
               val_in   = req_value;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in.read_value = '0;
            res_in.status     = ST_DONE;
            case (mode_ff)
               MODE_READ: begin
                  if (pos_ff < count_ff) begin
                     rd_en    = 1'b1;
                     rd_addr  = pos_ff[AddrW-1:0];
                     state_in = S_RD_WAIT;
                  end else begin
                     res_in.read_value = READ_MISS;
                     res_in.status     = ST_RANGE;
                     state_in          = S_FINISH;
                  end
               end
               MODE_HEAD, MODE_TAIL, MODE_AT: begin
                  if (tgt > count_ff) begin
                     res_in.status = ST_RANGE;
                     state_in      = S_FINISH;
                  end else if (count_ff >= CapCount) begin
                     res_in.status = ST_FULL;
                     state_in      = S_FINISH;
                  end else begin
                     idx_in   = count_ff;
                     tgt_in   = tgt;
                     state_in = S_UP;
                  end
               end
               MODE_DELETE: begin
                  if (pos_ff < count_ff) begin
                     idx_in   = pos_ff;
                     state_in = S_DOWN;
                  end else begin
                     res_in.status = ST_RANGE;
                     state_in      = S_FINISH;
                  end
               end
               default: begin
                  res_in.status = ST_RANGE;
                  state_in      = S_FINISH;
               end
            endcase
         end
         S_RD_WAIT: begin
            res_in.read_value = rd_data;
            state_in          = S_FINISH;
         end
         S_UP: begin
            if (idx_ff > tgt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_m1[AddrW-1:0];
               state_in = S_UP_WR;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CntW'(1);
               state_in = S_FINISH;
            end
         end
         S_UP_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_m1;
            state_in = S_UP;
         end
         S_DOWN: begin
            if (idx_p1 < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_p1[AddrW-1:0];
               state_in = S_DN_WR;
            end else begin
               count_in = count_ff - CntW'(1);
               state_in = S_FINISH;
            end
         end
         S_DN_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_p1;
            state_in = S_DOWN;
         end
         S_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      mode_ff <= mode_in;
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      idx_ff  <= idx_in;
      tgt_ff  <= tgt_in;
      res_ff  <= res_in;
   end

   assign ready  = (state_ff == S_IDLE);
   assign res    = res_ff;
   assign length = count_ff;

endmodule

### rtl/indexed_ordered_list.sv
// Top level of the indexed ordered list: sequencer, element RAM and result register.
//
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_stall  mode, position, value
//   rsp_     out        rsp_valid/rsp_stall  read_value, status, length
//
// A read hit reads the RAM once. An insert at p into n elements shifts the n-p elements
// at and above p up by one; a delete at p shifts the n-1-p elements above p down by one;
// a read miss, rejected request or unused mode goes straight to the result. Each shift
// step reads a neighbor and writes it back. Reset clears the length and control state;
// elements need no clearing pass. A stalled result lets the next request in; a finished
// one holds in the sequencer until the register frees.
module indexed_ordered_list import iol_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [MODE_W-1:0]              req_mode,
   input  logic [$clog2(CAPACITY+1)-1:0]  req_position,
   input  logic signed [VALUE_W-1:0]      req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [VALUE_W-1:0]      rsp_read_value,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]  rsp_length
);

   localparam int CntW  = $clog2(CAPACITY + 1);
   localparam int AddrW = $clog2(CAPACITY);

   logic                      seq_ready;
   logic                      seq_done;
   res_type                   seq_res;
   logic [CntW-1:0]           seq_length;
   logic                      out_free;
   logic                      wr_en;
   logic [AddrW-1:0]          wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic                      rd_en;
   logic [AddrW-1:0]          rd_addr;
   logic [VALUE_W-1:0]        rd_data;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_read_value_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [CntW-1:0]           rsp_length_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !seq_ready;

   iol_seq #(
      .CAPACITY(CAPACITY)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_mode    (req_mode),
      .req_position(req_position),
      .req_value   (req_value),
      .out_free    (out_free),
      .ready       (seq_ready),
      .done        (seq_done),
      .res         (seq_res),
      .length      (seq_length),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   iol_ram #(
      .Width(VALUE_W),
      .Depth(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_valid_in = seq_done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (seq_done) begin
         rsp_read_value_ff <= seq_res.read_value;
         rsp_status_ff     <= seq_res.status;
         rsp_length_ff     <= seq_length;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;

endmodule

### rtl/iol_check.sv
// Port-level checks for the indexed ordered list, bound to the top level.
module iol_check import iol_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [VALUE_W-1:0]      rsp_read_value,
   input logic [STATUS_W-1:0]            rsp_status,
   input logic [$clog2(CAPACITY+1)-1:0]  rsp_length
);

   localparam int CntW = $clog2(CAPACITY + 1);

   hold_stalled_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_length))
      else $error("stalled result beat changed");

   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one still in progress");

   full_means_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_length == CntW'(CAPACITY))
      else $error("list full reported below capacity");

   length_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length <= CntW'(CAPACITY)
         && (rsp_status == ST_DONE || rsp_status == ST_RANGE || rsp_status == ST_FULL))
      else $error("result length or status out of bounds");

endmodule

bind indexed_ordered_list iol_check #(.CAPACITY(CAPACITY)) u_check (.*);

### tb/tb_indexed_ordered_list.sv
// Testbench for the indexed ordered list: directed table, then randomized fill/drain runs.
`timescale 1ns / 1ps

module tb_indexed_ordered_list;
   import iol_pkg::*;

   localparam int CAPACITY = 64;
   localparam int POS_W    = $clog2(CAPACITY + 1);
   localparam int N_ITEMS  = 550;
   localparam int DRAIN_CYCLES = 4 + 2 * CAPACITY + 20;

   localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [STATUS_W-1:0]       status;
      logic [POS_W-1:0]          length;
   } outcome_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
      bit                        typed;
      outcome_type               result;
   } probe_row_type;

   localparam int N_PROBES = 25;

   probe_row_type probe_rows [N_PROBES] = '{
      '{MODE_READ,   7'd0,   32'sd0,           1'b1, '{READ_MISS, ST_RANGE, 7'd0}},
      '{MODE_DELETE, 7'd0,   32'sd0,           1'b1, '{32'sd0, ST_RANGE, 7'd0}},
      '{MODE_AT,     7'd1,   32'sd5,           1'b1, '{32'sd0, ST_RANGE, 7'd0}},
      '{MODE_RSVD5,  7'd0,   32'sd0,           1'b1, '{32'sd0, ST_RANGE, 7'd0}},
      '{MODE_RSVD7,  7'd127, -32'sd1,          1'b1, '{32'sd0, ST_RANGE, 7'd0}},
      '{MODE_HEAD,   7'd0,   32'sh7FFFFFFF,    1'b1, '{32'sd0, ST_DONE, 7'd1}},
      '{MODE_TAIL,   7'd127, 32'sh80000000,    1'b1, '{32'sd0, ST_DONE, 7'd2}},
      '{MODE_AT,     7'd1,   -32'sd1,          1'b1, '{32'sd0, ST_DONE, 7'd3}},
      '{MODE_AT,     7'd3,   32'sd0,           1'b1, '{32'sd0, ST_DONE, 7'd4}},
      '{MODE_READ,   7'd0,   32'sd0,           1'b1, '{32'sh7FFFFFFF, ST_DONE, 7'd4}},
      '{MODE_READ,   7'd1,   32'sd0,           1'b1, '{-32'sd1, ST_DONE, 7'd4}},
      '{MODE_READ,   7'd2,   32'sd0,           1'b1, '{32'sh80000000, ST_DONE, 7'd4}},
      '{MODE_READ,   7'd3,   32'sd0,           1'b1, '{32'sd0, ST_DONE, 7'd4}},
      '{MODE_READ,   7'd4,   32'sd0,           1'b1, '{READ_MISS, ST_RANGE, 7'd4}},
      '{MODE_READ,   7'd127, 32'sd0,           1'b1, '{READ_MISS, ST_RANGE, 7'd4}},
      '{MODE_DELETE, 7'd1,   32'sd0,           1'b1, '{32'sd0, ST_DONE, 7'd3}},
      '{MODE_DELETE, 7'd2,   32'sd0,           1'b1, '{32'sd0, ST_DONE, 7'd2}},
      '{MODE_DELETE, 7'd64,  32'sd0,           1'b1, '{32'sd0, ST_RANGE, 7'd2}},
      '{MODE_RSVD6,  7'd1,   32'sd0,           1'b1, '{32'sd0, ST_RANGE, 7'd2}},
      '{MODE_AT,     7'd127, 32'sd1234,        1'b1, '{32'sd0, ST_RANGE, 7'd2}},
      '{MODE_AT,     7'd0,   32'sh5555AAAA,    1'b0, '{32'sd0, ST_DONE, 7'd0}},
      '{MODE_READ,   7'd1,   32'sd0,           1'b0, '{32'sd0, ST_DONE, 7'd0}},
      '{MODE_DELETE, 7'd0,   32'sd0,           1'b0, '{32'sd0, ST_DONE, 7'd0}},
      '{MODE_HEAD,   7'd0,   32'shAAAA5555,    1'b0, '{32'sd0, ST_DONE, 7'd0}},
      '{MODE_READ,   7'd0,   32'sd0,           1'b0, '{32'sd0, ST_DONE, 7'd0}}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode = MODE_READ;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic [POS_W-1:0]          rsp_length;

   logic signed [VALUE_W-1:0] list_mem [CAPACITY];
   int unsigned               list_len = 0;
   outcome_type               outcomes_due [$];
   int                        failures = 0;
   bit                        steady = 1'b0;

   indexed_ordered_list #(.CAPACITY(CAPACITY)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_value(rsp_read_value),
      .rsp_status    (rsp_status),
      .rsp_length    (rsp_length)
   );

   always #5 clock = ~clock;

   function automatic logic [STATUS_W-1:0] place_value(input int unsigned pos,
                                                     input logic signed [VALUE_W-1:0] val);
      int unsigned i;
      if (pos > list_len) return ST_RANGE;
      if (list_len >= CAPACITY) return ST_FULL;
      for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
      list_mem[pos] = val;
      list_len++;
      return ST_DONE;
   endfunction

   function automatic outcome_type apply_request(input logic [MODE_W-1:0] m,
                                                 input logic [POS_W-1:0] p,
                                                 input logic signed [VALUE_W-1:0] v);
      outcome_type o;
      int unsigned i;
      o.read_value = '0;
      o.status     = ST_DONE;
      case (m)
         MODE_READ: begin
            if (p < list_len) o.read_value = list_mem[p];
            else begin
               o.read_value = READ_MISS;
               o.status     = ST_RANGE;
            end
         end
         MODE_HEAD:   o.status = place_value(0, v);
         MODE_TAIL:   o.status = place_value(list_len, v);
         MODE_AT:     o.status = place_value(p, v);
         MODE_DELETE: begin
            if (p < list_len) begin
               for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end else o.status = ST_RANGE;
         end
         default:     o.status = ST_RANGE;
      endcase
      o.length = POS_W'(list_len);
      return o;
   endfunction

   task automatic send_beat(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                            input logic signed [VALUE_W-1:0] v, input bit typed,
                            input outcome_type typed_out);
      outcome_type predicted;
      while (!steady && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_position <= p;
      req_value    <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_request(m, p, v);
      outcomes_due.push_back(typed ? typed_out : predicted);
   endtask

   task automatic send_random(input int insert_pct, input int delete_pct);
      logic [MODE_W-1:0]         m;
      logic [POS_W-1:0]          p;
      logic signed [VALUE_W-1:0] v;
      int                        r;
      r = $urandom_range(99);
      if (r < 3) begin
         case ($urandom_range(2))
            0:       m = MODE_RSVD5;
            1:       m = MODE_RSVD6;
            default: m = MODE_RSVD7;
         endcase
      end else if (r < 3 + insert_pct) begin
         case ($urandom_range(2))
            0:       m = MODE_HEAD;
            1:       m = MODE_TAIL;
            default: m = MODE_AT;
         endcase
      end else if (r < 3 + insert_pct + delete_pct) m = MODE_DELETE;
      else m = MODE_READ;
      if ($urandom_range(9) < 8) p = POS_W'($urandom_range(list_len));
      else p = POS_W'($urandom_range(127));
      case ($urandom_range(7))
         0:       v = 32'sh7FFFFFFF;
         1:       v = 32'sh80000000;
         default: v = $urandom;
      endcase
      send_beat(m, p, v, 1'b0, '0);
   endtask

   always @(posedge clock)
      rsp_stall <= !steady && ($urandom_range(99) < 27);

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            $error("rsp beat with no outcome pending");
            failures++;
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %0d, got %0d", want.read_value, rsp_read_value);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_length);
               failures++;
            end
         end
      end
   end

   initial begin
      int sent;
      int run_left;
      int ins_pct;
      int del_pct;
      int k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (k = 0; k < N_PROBES; k++)
         send_beat(probe_rows[k].mode, probe_rows[k].position, probe_rows[k].value,
                   probe_rows[k].typed, probe_rows[k].result);
      sent     = 0;
      run_left = 120;
      ins_pct  = 80;
      del_pct  = 5;
      while (sent < N_ITEMS) begin
         if (run_left == 0) begin
            run_left = $urandom_range(100, 40);
            case ($urandom_range(2))
               0: begin ins_pct = 75; del_pct = 10; end
               1: begin ins_pct = 10; del_pct = 70; end
               default: begin ins_pct = 35; del_pct = 35; end
            endcase
         end
         steady = (sent >= 250 && sent < 350);
         send_random(ins_pct, del_pct);
         run_left--;
         sent++;
      end
      req_valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) $display("tb_indexed_ordered_list passed");
      else $display("tb_indexed_ordered_list failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_indexed_ordered_list failed");
      $finish;
   end

endmodule
